[rtl/tile_slot_cache_oldest_replacement_assert.svh]
// Assertion macros shared by the tile slot cache checkers.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef TILE_SLOT_CACHE_OLDEST_REPLACEMENT_ASSERT_SVH
`define TILE_SLOT_CACHE_OLDEST_REPLACEMENT_ASSERT_SVH

// Antecedent and consequent checked at the same clock edge.
`define TSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile slot cache check failed");

// Consequent checked at the clock edge after the antecedent.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile slot cache check failed");

`endif

[rtl/tsc_pkg.sv]
// Package for the tile slot cache: field widths and the slot memory port types.
// Used by the interfaces, the slot memory, the controller and the top level.
package tsc_pkg;

    localparam int TILE_W = 12;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 8;
    localparam int CFG_W  = 9;

    // Reset value of the slot count register.
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 9'd256;

    // One slot as seen at the memory read port.
    typedef struct packed {
        logic              occupied;
        logic [TILE_W-1:0] tile;
        logic [TIME_W-1:0] load_time;
    } t_mem_rd;

    // Write request into the slot memory (address travels separately).
    typedef struct packed {
        logic              en;
        logic [TILE_W-1:0] tile;
        logic [TIME_W-1:0] load_time;
    } t_mem_wr;

endpackage

[rtl/tsc_req_if.sv]
// Request channel of the tile slot cache: one tile lookup per transaction.
// Depends on tsc_pkg for the field widths.
interface tsc_req_if
    import tsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TILE_W-1:0] tile_index;
    logic [TIME_W-1:0] frame_time;

    modport source (output valid, output tile_index, output frame_time, input ready);
    modport sink   (input valid, input tile_index, input frame_time, output ready);
endinterface

[rtl/tsc_rsp_if.sv]
// Response channel of the tile slot cache: one result per request transaction.
// Depends on tsc_pkg for the field widths.
interface tsc_rsp_if
    import tsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [TILE_W-1:0] evicted_tile;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_tile, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_tile, output ready);
endinterface

[rtl/tsc_mem.sv]
// Slot memory: tile and load time per slot, one write and one registered read port.
// Depends on tsc_pkg; occupied flags sit in flip-flops so reset empties all slots at once.
module tsc_mem
    import tsc_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_mem_rd       o_rd_data,
    input  t_mem_wr       i_wr,
    input  logic [IW-1:0] i_wr_addr
);

    logic [TILE_W+TIME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_valid;
    logic [TILE_W+TIME_W-1:0] r_rdata;
    logic                     r_rvalid;

    // Payload storage and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= {i_wr.tile, i_wr.load_time};
        end
        if (i_rd_en) begin
            r_rdata  <= r_mem[i_rd_addr];
            r_rvalid <= r_valid[i_rd_addr];
        end
    end

    // Occupied flags; a slot never written reads as empty with tile 0 and time 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        o_rd_data.occupied  = r_rvalid;
        o_rd_data.tile      = r_rvalid ? r_rdata[TILE_W+TIME_W-1:TIME_W] : '0;
        o_rd_data.load_time = r_rvalid ? r_rdata[TIME_W-1:0] : '0;
    end

endmodule

[rtl/tsc_ctrl.sv]
// Lookup controller: walks the slot memory, finds a hit or the oldest slot, writes back.
// Depends on tsc_pkg and the request and response interfaces.
module tsc_ctrl
    import tsc_pkg::*;
#(
    parameter int SLOTS = 256,
    parameter int IW    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_slots_in_use,
    tsc_req_if.sink          i_req,
    tsc_rsp_if.source        o_rsp,
    output logic             o_rd_en,
    output logic [IW-1:0]    o_rd_addr,
    input  t_mem_rd          i_rd_data,
    output t_mem_wr          o_wr,
    output logic [IW-1:0]    o_wr_addr
);

    localparam logic [CFG_W-1:0] SLOTS_CFG = CFG_W'(SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_DONE} t_state;

    t_state            r_state;
    logic [TILE_W-1:0] r_tile;
    logic [TIME_W-1:0] r_now;
    logic [IW-1:0]     r_last;
    logic [IW-1:0]     r_addr;
    logic              r_issued;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic [IW-1:0]     r_pick;
    logic              r_pick_occ;
    logic [TILE_W-1:0] r_pick_tile;
    logic [TIME_W-1:0] r_oldest;
    logic              r_res_hit;
    logic [IW-1:0]     r_res_slot;
    logic              r_res_ev;
    logic [TILE_W-1:0] r_res_ev_tile;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_ev;
    logic [TILE_W-1:0] r_out_ev_tile;

    logic [CFG_W-1:0]  last_wide;
    logic [IW-1:0]     last_idx;
    logic              accept;
    logic              match;
    logic [TIME_W-1:0] cur_oldest;
    logic              older;
    logic              take;

    // Highest slot index searched; zero acts as one slot, large values clamp to SLOTS.
    always_comb begin
        if (i_slots_in_use == '0) begin
            last_wide = '0;
        end else if (i_slots_in_use > SLOTS_CFG) begin
            last_wide = SLOTS_CFG - 1'b1;
        end else begin
            last_wide = i_slots_in_use - 1'b1;
        end
        last_idx = last_wide[IW-1:0];
    end

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Read issue: one slot address per cycle until the last active slot.
    assign o_rd_en   = (r_state == S_SCAN) && !r_issued;
    assign o_rd_addr = r_addr;

    // Compare the slot returned this cycle against the request.
    always_comb begin
        match      = i_rd_data.occupied && (i_rd_data.tile == r_tile);
        cur_oldest = (r_rd_idx == '0) ? r_now : r_oldest;
        older      = i_rd_data.load_time < cur_oldest;
        take       = (r_rd_idx == '0) || older;
    end

    // Write back the new tile into the chosen slot on a miss.
    always_comb begin
        o_wr.en        = (r_state == S_WRITE);
        o_wr.tile      = r_tile;
        o_wr.load_time = r_now;
        o_wr_addr      = r_pick;
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.evicted_valid = r_out_ev;
    assign o_rsp.evicted_tile  = r_out_ev_tile;

    // Sequencer, scan bookkeeping and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issued  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= o_rd_en;
            r_rd_idx <= r_addr;
            // In S_DONE the result load below decides the valid flag on its own.
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tile   <= i_req.tile_index;
                        r_now    <= i_req.frame_time;
                        r_last   <= last_idx;
                        r_addr   <= '0;
                        r_issued <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (o_rd_en) begin
                        if (r_addr == r_last) begin
                            r_issued <= 1'b1;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_vld) begin
                        if (match) begin
                            r_res_hit     <= 1'b1;
                            r_res_slot    <= r_rd_idx;
                            r_res_ev      <= 1'b0;
                            r_res_ev_tile <= '0;
                            r_state       <= S_DONE;
                        end else begin
                            if (take) begin
                                r_pick      <= r_rd_idx;
                                r_pick_occ  <= i_rd_data.occupied;
                                r_pick_tile <= i_rd_data.tile;
                                r_oldest    <= older ? i_rd_data.load_time : r_now;
                            end
                            if (r_rd_idx == r_last) begin
                                r_state <= S_WRITE;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    r_res_hit     <= 1'b0;
                    r_res_slot    <= r_pick;
                    r_res_ev      <= r_pick_occ;
                    r_res_ev_tile <= r_pick_occ ? r_pick_tile : '0;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld     <= 1'b1;
                        r_out_hit     <= r_res_hit;
                        r_out_slot    <= SLOT_W'(r_res_slot);
                        r_out_ev      <= r_res_ev;
                        r_out_ev_tile <= r_res_ev_tile;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/tile_slot_cache_oldest_replacement.sv]
// Tile slot cache with oldest-load replacement: n = clamped slots_in_use active slots.
// One request is served at a time, limited by the single read port of the slot memory,
// which is walked one slot per cycle over the n active slots.
// Reset (synchronous, active low) empties all slots at once and sets slots_in_use to 256.
// A finished result waits in the output register while the next request is accepted.
module tile_slot_cache_oldest_replacement
    import tsc_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tsc_req_if.sink          i_req,
    tsc_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);

    logic [CFG_W-1:0] r_slots_in_use;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    t_mem_rd          rd_data;
    t_mem_wr          wr;
    logic [IW-1:0]    wr_addr;

    // Slot count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SLOTS_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    tsc_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slots_in_use (r_slots_in_use),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr           (wr),
        .o_wr_addr      (wr_addr)
    );

    tsc_mem #(
        .DEPTH (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr),
        .i_wr_addr (wr_addr)
    );

endmodule

[rtl/tsc_chk.sv]
// Port-level checker for the tile slot cache, bound to the top level.
// Depends on tsc_pkg and the assertion macros header.
`include "tile_slot_cache_oldest_replacement_assert.svh"

module tsc_chk
    import tsc_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_rsp_hit,
    input logic [SLOT_W-1:0] i_rsp_slot,
    input logic              i_rsp_ev_valid,
    input logic [TILE_W-1:0] i_rsp_ev_tile
);

    // A hit never evicts anything.
    `TSC_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, i_rsp_valid && i_rsp_hit, !i_rsp_ev_valid)

    // Without an eviction the evicted tile reads as zero.
    `TSC_ASSERT_NOW(a_ev_tile_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ev_valid,
                    i_rsp_ev_tile == '0)

    // The reported slot lies inside the slot memory.
    `TSC_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, i_rsp_valid, 32'(i_rsp_slot) < SLOTS)

    // Requests are served one at a time: no back-to-back accepts.
    `TSC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A stalled result holds its contents.
    `TSC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
                     i_rsp_valid && $stable({i_rsp_hit, i_rsp_slot, i_rsp_ev_valid,
                                             i_rsp_ev_tile}))

endmodule

bind tile_slot_cache_oldest_replacement tsc_chk #(
    .SLOTS (SLOTS)
) u_tsc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_hit      (o_rsp.hit),
    .i_rsp_slot     (o_rsp.slot),
    .i_rsp_ev_valid (o_rsp.evicted_valid),
    .i_rsp_ev_tile  (o_rsp.evicted_tile)
);

[bench/tile_cache_checker.sv]
// Checker for the tile slot cache: tracks slot contents, predicts each lookup, compares responses.
// Depends on tsc_pkg and on the tsc_req_if and tsc_rsp_if interfaces.
`timescale 1ns / 100ps

module tile_cache_checker
    import tsc_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tsc_req_if               i_req,
    tsc_rsp_if               i_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    // Outcome of one tile lookup, laid out like the response channel.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [TILE_W-1:0] evicted_tile;
    } t_lookup_result;

    // Shadow copy of the slot table and the slot count register.
    logic [TILE_W-1:0] shadow_tile[SLOTS];
    logic              shadow_occupied[SLOTS];
    logic [TIME_W-1:0] shadow_load_time[SLOTS];
    logic [CFG_W-1:0]  slot_count;

    t_lookup_result    pending_lookups[$];

    // The register value is clamped into 1..SLOTS before use.
    function automatic int active_slots();
        if (slot_count == '0) begin
            return 1;
        end
        if (int'(slot_count) > SLOTS) begin
            return SLOTS;
        end
        return int'(slot_count);
    endfunction

    // Searches the active slots; on a miss, replaces the oldest slot loaded before now, or slot 0 if none is.
    task automatic lookup_tile(input logic [TILE_W-1:0] tile, input logic [TIME_W-1:0] now,
                               output t_lookup_result res);
        int                n;
        int                pick;
        bit                found;
        logic [TIME_W-1:0] oldest;
        n      = active_slots();
        res    = '0;
        found  = 1'b0;
        pick   = 0;
        oldest = now;
        for (int i = 0; i < n && !found; i++) begin
            if (shadow_occupied[i] && shadow_tile[i] == tile) begin
                found    = 1'b1;
                res.hit  = 1'b1;
                res.slot = i[SLOT_W-1:0];
            end
        end
        if (!found) begin
            // Strictly older wins; ties keep the lower index.
            for (int i = 0; i < n; i++) begin
                if (shadow_load_time[i] < oldest) begin
                    oldest = shadow_load_time[i];
                    pick   = i;
                end
            end
            res.slot = pick[SLOT_W-1:0];
            if (shadow_occupied[pick]) begin
                res.evicted_valid = 1'b1;
                res.evicted_tile  = shadow_tile[pick];
            end
            shadow_tile[pick]      = tile;
            shadow_occupied[pick]  = 1'b1;
            shadow_load_time[pick] = now;
        end
    endtask

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("%0t ns: slot cache mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // Watch both channels and the register port at each rising edge.
    always @(posedge i_clk) begin
        t_lookup_result want;
        t_lookup_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_tile[i]      = '0;
                shadow_occupied[i]  = 1'b0;
                shadow_load_time[i] = '0;
            end
            slot_count = SLOTS_IN_USE_RST;
            pending_lookups.delete();
        end else begin
            if (i_cfg_we) begin
                slot_count = i_cfg_data;
            end
            if (i_req.valid && i_req.ready) begin
                lookup_tile(i_req.tile_index, i_req.frame_time, want);
                pending_lookups = {pending_lookups, want};
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.hit, i_rsp.slot, i_rsp.evicted_valid, i_rsp.evicted_tile};
                if (pending_lookups.size() == 0) begin
                    report_mismatch("response transaction with no request outstanding");
                end else begin
                    want = pending_lookups.pop_front();
                    if (got.hit !== want.hit) begin
                        report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
                    end
                    if (got.slot !== want.slot) begin
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  got.slot, want.slot));
                    end
                    if (got.evicted_valid !== want.evicted_valid) begin
                        report_mismatch($sformatf("evicted_valid %0b, expected %0b",
                                                  got.evicted_valid, want.evicted_valid));
                    end
                    if (got.evicted_tile !== want.evicted_tile) begin
                        report_mismatch($sformatf("evicted_tile %0d, expected %0d",
                                                  got.evicted_tile, want.evicted_tile));
                    end
                end
            end
        end
        o_pending = pending_lookups.size();
    end

endmodule

[bench/tb_top.sv]
// Top of the tile slot cache testbench: clock, reset, request stimulus, response stalls, verdict.
// Depends on tsc_pkg, both channel interfaces, the cache itself and tile_cache_checker.
`timescale 1ns / 100ps

module tb_top;
    import tsc_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    tsc_req_if req_ch ();
    tsc_rsp_if rsp_ch ();

    int               pending;
    int               fail_count;
    bit               calm;
    logic [TIME_W-1:0] now_ticks;

    tile_slot_cache_oldest_replacement u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    tile_cache_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 12 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Response side: ready drops in random bursts of stalls; no new burst starts once calm is set.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Drives one request and holds it until the transaction completes.
    task automatic send_request(input logic [TILE_W-1:0] tile, input logic [TIME_W-1:0] ticks);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.tile_index <= tile;
        req_ch.frame_time <= ticks;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Frame time mostly creeps forward, now and then jumps anywhere, backwards included.
    task automatic advance_frame_time();
        if ($urandom_range(0, 39) == 0) begin
            now_ticks = $urandom();
        end else begin
            now_ticks = now_ticks + $urandom_range(0, 2);
        end
    endtask

    // Lets the cache drain completely, then writes the slot count.
    task automatic set_slot_count(input logic [CFG_W-1:0] count);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random lookups drawn mostly from a pool a little larger than the active slots.
    task automatic run_phase(input logic [CFG_W-1:0] count, input int items, input int base);
        int                n;
        int                pool;
        logic [TILE_W-1:0] tile;
        set_slot_count(count);
        n    = (count == 0) ? 1 : ((count > 256) ? 256 : int'(count));
        pool = n + n / 2 + 2;
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                tile = TILE_W'($urandom_range(0, 4095));
            end else begin
                tile = TILE_W'((base + $urandom_range(0, pool - 1)) % 4096);
            end
            advance_frame_time();
            send_request(tile, now_ticks);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [CFG_W-1:0] phase_count[12];
        int               phase_items[12];
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.tile_index = '0;
        req_ch.frame_time = '0;
        rsp_ch.ready      = 1'b0;
        calm              = 1'b0;
        now_ticks         = 32'd1000;
        phase_count = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd8, 9'd16, 9'd5, 9'd256, 9'd511, 9'd300,
                        9'd32, 9'd4};
        phase_items = '{150, 150, 150, 100, 200, 200, 150, 150, 60, 60, 200, 150};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lookups with all 256 slots active, straight out of reset.
        // Empty slots never hit, even for tile 0 which matches their cleared contents.
        send_request(12'd0, 32'd0);
        send_request(12'd0, 32'd0);
        // Nothing loaded before time 0, so slot 0 is replaced although occupied.
        send_request(12'hFFF, 32'd0);
        send_request(12'hFFF, 32'd0);
        // Empty slots carry load time 0 and compete with slot 0 on the lowest index.
        send_request(12'd1, 32'd1);
        send_request(12'd2, 32'd1);
        send_request(12'd3, 32'd2);
        send_request(12'd2, 32'd2);
        send_request(12'd5, 32'hFFFF_FFFF);
        send_request(12'd6, 32'hFFFF_FFFF);
        send_request(12'd5, 32'hFFFF_FFFF);
        send_request(12'd7, 32'h8000_0000);
        // Time going backwards.
        send_request(12'd8, 32'd3);
        send_request(12'd9, 32'd0);
        send_request(12'hAAA, 32'h5555_5555);
        send_request(12'h555, 32'hAAAA_AAAA);
        send_request(12'hAAA, 32'hAAAA_AAAB);
        send_request(12'd4095, 32'hFFFF_FFFE);
        send_request(12'd3, 32'hFFFF_FFFF);

        // Random phases over several slot counts; the last one runs without idling.
        for (int p = 0; p < 12; p++) begin
            if (p == 11) begin
                calm = 1'b1;
            end
            run_phase(phase_count[p], phase_items[p], (p % 3 == 0) ? 0 : 4000 - 97 * p);
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
